[sv/psor_pkg.sv]
package psor_pkg;

    localparam int COORD_W    = 24;
    localparam int PIX_W      = 16;
    localparam int COUNT_W    = 16;
    localparam int EDGE_W     = 25;
    localparam int SQ_W       = 2 * EDGE_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    // Command fields sized for the largest supported half window of eight.
    localparam int SLOT_MAX_W = 4;
    localparam int EIDX_MAX_W = 4;
    localparam int WCNT_MAX_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLED     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_THRESHOLD = 1'b1;

    localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET = 24'd128;
    localparam logic [COUNT_W-1:0]    COUNT_SAT       = 16'hFFFF;

    localparam logic [1:0] OSEL_CUR = 2'd0;
    localparam logic [1:0] OSEL_MEM = 2'd1;
    localparam logic [1:0] OSEL_END = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [PIX_W-1:0]          pixel_col;
        logic [PIX_W-1:0]          pixel_row;
        logic                      last_in_frame;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic [PIX_W-1:0]          out_col;
        logic [PIX_W-1:0]          out_row;
        logic                      is_frame_end;
        logic [COUNT_W-1:0]        kept_count;
    } t_out;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [PIX_W-1:0]   col;
        logic [PIX_W-1:0]   row;
    } t_point;

    typedef struct packed {
        logic                  capture;
        logic [SLOT_MAX_W-1:0] wr_slot;
        logic [SLOT_MAX_W-1:0] rd_slot;
        logic                  sq_run;
        logic [2:0]            sq_phase;
        logic                  sqrt_init;
        logic                  sqrt_step;
        logic                  edge_we;
        logic [EIDX_MAX_W-1:0] edge_wr;
        logic                  sum_clr;
        logic                  sum_add;
        logic [EIDX_MAX_W-1:0] edge_rd;
        logic [WCNT_MAX_W-1:0] win_count;
        logic                  out_load;
        logic [1:0]            out_sel;
        logic [COUNT_W-1:0]    kept_count;
    } t_dp_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic keep;
        logic out_free;
    } t_dp_stat;

endpackage

[sv/psor_dpath.sv]
module psor_dpath #(
    parameter int HALF_WINDOW = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  psor_pkg::t_in                   i_in,
    input  logic                            i_cfg_we,
    input  logic [psor_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psor_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  psor_pkg::t_dp_cmd               i_cmd,
    output psor_pkg::t_dp_stat              o_stat,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output psor_pkg::t_out                  o_out
);

    localparam int PD = HALF_WINDOW + 1;
    localparam int ED = 2 * HALF_WINDOW;
    localparam int SW = $clog2(PD);
    localparam int EW = $clog2(ED);
    localparam int NW = $clog2(ED + 1);
    localparam int LW = psor_pkg::EDGE_W + NW;
    localparam int EWD = psor_pkg::EDGE_W;
    localparam int QW = psor_pkg::SQ_W;

    logic [psor_pkg::CFG_DATA_W-1:0] r_thr;
    psor_pkg::t_point r_cur;
    psor_pkg::t_point r_prev;
    psor_pkg::t_point r_mem [PD];
    psor_pkg::t_point r_rd;
    logic [EWD-1:0] r_diff;
    logic [QW-1:0]  r_prod;
    logic [QW-1:0]  r_acc;
    logic [QW-1:0]  r_rem;
    logic [QW-1:0]  r_root;
    logic [QW-1:0]  r_bit;
    logic [EWD-1:0] r_edges [ED];
    logic [LW-1:0]  r_wsum;
    logic [LW-1:0]  r_limit;
    psor_pkg::t_out r_out;
    logic           r_out_valid;

    psor_pkg::t_point pt_in;
    logic [psor_pkg::COORD_W-1:0] op_a;
    logic [psor_pkg::COORD_W-1:0] op_b;
    logic signed [EWD-1:0] diff_s;
    logic [EWD-1:0] diff_abs;
    logic [QW-1:0]  sq;
    logic [QW-1:0]  trial;
    logic [SW-1:0]  wr_idx;
    logic [SW-1:0]  rd_idx;
    logic [EW-1:0]  ewr_idx;
    logic [EW-1:0]  erd_idx;
    psor_pkg::t_out out_sel;

    assign pt_in = '{x: i_in.coord_x, y: i_in.coord_y, z: i_in.coord_z,
                     col: i_in.pixel_col, row: i_in.pixel_row};
    assign wr_idx  = i_cmd.wr_slot[SW-1:0];
    assign rd_idx  = i_cmd.rd_slot[SW-1:0];
    assign ewr_idx = i_cmd.edge_wr[EW-1:0];
    assign erd_idx = i_cmd.edge_rd[EW-1:0];

    always_comb begin
        case (i_cmd.sq_phase)
            3'd0: begin
                op_a = r_cur.x;
                op_b = r_prev.x;
            end
            3'd1: begin
                op_a = r_cur.y;
                op_b = r_prev.y;
            end
            default: begin
                op_a = r_cur.z;
                op_b = r_prev.z;
            end
        endcase
        diff_s   = $signed({op_a[psor_pkg::COORD_W-1], op_a})
                 - $signed({op_b[psor_pkg::COORD_W-1], op_b});
        diff_abs = diff_s[EWD-1] ? EWD'(-diff_s) : EWD'(diff_s);
    end

    assign sq    = r_diff * r_diff;
    assign trial = r_root + r_bit;

    always_comb begin
        out_sel = '0;
        case (i_cmd.out_sel)
            psor_pkg::OSEL_CUR: begin
                out_sel.out_x   = r_cur.x;
                out_sel.out_y   = r_cur.y;
                out_sel.out_z   = r_cur.z;
                out_sel.out_col = r_cur.col;
                out_sel.out_row = r_cur.row;
            end
            psor_pkg::OSEL_MEM: begin
                out_sel.out_x   = r_rd.x;
                out_sel.out_y   = r_rd.y;
                out_sel.out_z   = r_rd.z;
                out_sel.out_col = r_rd.col;
                out_sel.out_row = r_rd.row;
            end
            default: begin
                out_sel.is_frame_end = 1'b1;
                out_sel.kept_count   = i_cmd.kept_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= psor_pkg::THRESHOLD_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == psor_pkg::REG_DISTANCE_THRESHOLD) begin
                r_thr <= i_cfg_data;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cur          <= pt_in;
            r_prev         <= r_cur;
            r_mem[wr_idx]  <= pt_in;
        end
        r_rd <= r_mem[rd_idx];

        // Squared distance: difference, square and accumulate as a short pipeline.
        if (i_cmd.sq_run) begin
            if (i_cmd.sq_phase < 3'd3) begin
                r_diff <= diff_abs;
            end
            if (i_cmd.sq_phase >= 3'd1 && i_cmd.sq_phase <= 3'd3) begin
                r_prod <= sq;
            end
            if (i_cmd.sq_phase == 3'd0) begin
                r_acc <= '0;
            end else if (i_cmd.sq_phase >= 3'd2) begin
                r_acc <= r_acc + r_prod;
            end
        end

        // Digit-by-digit square root, two radicand bits per step.
        if (i_cmd.sqrt_init) begin
            r_rem  <= r_acc;
            r_root <= '0;
            r_bit  <= QW'(1) << (QW - 2);
        end else if (i_cmd.sqrt_step) begin
            if (r_rem >= trial) begin
                r_rem  <= r_rem - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end

        if (i_cmd.edge_we) begin
            r_edges[ewr_idx] <= r_root[EWD-1:0];
        end

        if (i_cmd.sum_clr) begin
            r_wsum  <= '0;
            r_limit <= LW'(r_thr) * LW'(i_cmd.win_count[NW-1:0]);
        end else if (i_cmd.sum_add) begin
            r_wsum <= r_wsum + LW'(r_edges[erd_idx]);
        end

        if (i_cmd.out_load) begin
            r_out <= out_sel;
        end
    end

    assign o_stat.sqrt_done = (r_bit == '0);
    assign o_stat.keep      = (r_wsum < r_limit);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_out            = r_out;

endmodule

[sv/psor_ctrl.sv]
module psor_ctrl #(
    parameter int HALF_WINDOW      = 3,
    parameter int MAX_FRAME_POINTS = 65535
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_last,
    input  logic                            i_cfg_we,
    input  logic [psor_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psor_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output psor_pkg::t_dp_cmd               o_cmd,
    input  psor_pkg::t_dp_stat              i_stat
);

    localparam int CW = $clog2(MAX_FRAME_POINTS + 1);
    localparam int IW = CW + 1;
    localparam int SW = $clog2(HALF_WINDOW + 1);
    localparam int EW = $clog2(2 * HALF_WINDOW);
    localparam int NW = $clog2(2 * HALF_WINDOW + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_EMIT_IN = 4'd1;
    localparam logic [3:0] S_SQ      = 4'd2;
    localparam logic [3:0] S_SQI     = 4'd3;
    localparam logic [3:0] S_SQRT    = 4'd4;
    localparam logic [3:0] S_DSETUP  = 4'd5;
    localparam logic [3:0] S_DSUM    = 4'd6;
    localparam logic [3:0] S_DCMP    = 4'd7;
    localparam logic [3:0] S_DEMIT   = 4'd8;
    localparam logic [3:0] S_POST    = 4'd9;
    localparam logic [3:0] S_TAILCHK = 4'd10;
    localparam logic [3:0] S_END     = 4'd11;

    logic [3:0]    r_state,    n_state;
    logic [CW-1:0] r_k,        n_k;
    logic [CW-1:0] r_kk,       n_kk;
    logic [CW-1:0] r_dec,      n_dec;
    logic [SW-1:0] r_dec_slot, n_dec_slot;
    logic [EW-1:0] r_dec_edge, n_dec_edge;
    logic [SW-1:0] r_wr_slot,  n_wr_slot;
    logic [EW-1:0] r_ewp,      n_ewp;
    logic [CW-1:0] r_kept,     n_kept;
    logic          r_mode,     n_mode;
    logic          r_enable;
    logic          r_last,     n_last;
    logic          r_tail,     n_tail;
    logic [2:0]    r_phase,    n_phase;
    logic [NW-1:0] r_ecnt,     n_ecnt;
    logic [EW-1:0] r_eptr,     n_eptr;

    logic          accept;
    logic          stored;
    logic          mode_now;
    logic [IW-1:0] i_ext;
    logic [IW-1:0] last_idx;
    logic [IW-1:0] w_start;
    logic [IW-1:0] w_hi;
    logic [IW-1:0] w_end;
    logic          win_ok;
    logic [NW-1:0] win_cnt;
    logic [EW:0]   eptr_sum;
    logic [EW-1:0] eptr0;
    logic [SW-1:0] dec_slot_nx;
    logic [EW-1:0] dec_edge_nx;
    logic [EW-1:0] eptr_nx;
    logic [EW-1:0] ewp_nx;
    logic [SW-1:0] wr_slot_nx;
    logic [3:0]    dec_done_state;
    logic [CW+15:0] kept_ext;
    logic [psor_pkg::COUNT_W-1:0] kept_sat;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign stored   = (r_k < CW'(MAX_FRAME_POINTS));
    assign mode_now = (r_k == '0) ? r_enable : r_mode;

    // Window bounds of the point under decision, clipped at the frame ends.
    always_comb begin
        i_ext    = IW'(r_dec);
        last_idx = r_tail ? (IW'(r_k) - IW'(1)) : IW'(r_kk);
        w_start  = (i_ext >= IW'(HALF_WINDOW)) ? (i_ext - IW'(HALF_WINDOW)) : '0;
        w_hi     = i_ext + IW'(HALF_WINDOW);
        w_end    = (w_hi < last_idx) ? w_hi : last_idx;
        win_ok   = (w_end > w_start);
        win_cnt  = NW'(w_end - w_start);
        eptr_sum = (EW + 1)'(r_dec_edge) + (EW + 1)'(HALF_WINDOW);
        if (eptr_sum >= (EW + 1)'(2 * HALF_WINDOW)) begin
            eptr_sum = eptr_sum - (EW + 1)'(2 * HALF_WINDOW);
        end
        eptr0 = (i_ext >= IW'(HALF_WINDOW)) ? EW'(eptr_sum) : '0;
    end

    assign dec_slot_nx = (r_dec_slot == SW'(HALF_WINDOW)) ? '0 : r_dec_slot + SW'(1);
    assign wr_slot_nx  = (r_wr_slot == SW'(HALF_WINDOW)) ? '0 : r_wr_slot + SW'(1);
    assign dec_edge_nx = (r_dec_edge == EW'(2 * HALF_WINDOW - 1)) ? '0 : r_dec_edge + EW'(1);
    assign eptr_nx     = (r_eptr == EW'(2 * HALF_WINDOW - 1)) ? '0 : r_eptr + EW'(1);
    assign ewp_nx      = (r_ewp == EW'(2 * HALF_WINDOW - 1)) ? '0 : r_ewp + EW'(1);
    assign dec_done_state = r_tail ? S_TAILCHK : S_POST;

    assign kept_ext = (CW + 16)'(r_kept);
    assign kept_sat = (kept_ext > (CW + 16)'(psor_pkg::COUNT_SAT))
                    ? psor_pkg::COUNT_SAT : kept_ext[15:0];

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_kk       = r_kk;
        n_dec      = r_dec;
        n_dec_slot = r_dec_slot;
        n_dec_edge = r_dec_edge;
        n_wr_slot  = r_wr_slot;
        n_ewp      = r_ewp;
        n_kept     = r_kept;
        n_mode     = r_mode;
        n_last     = r_last;
        n_tail     = r_tail;
        n_phase    = r_phase;
        n_ecnt     = r_ecnt;
        n_eptr     = r_eptr;

        o_cmd            = '0;
        o_cmd.wr_slot    = psor_pkg::SLOT_MAX_W'(r_wr_slot);
        o_cmd.rd_slot    = psor_pkg::SLOT_MAX_W'(r_dec_slot);
        o_cmd.sq_phase   = r_phase;
        o_cmd.edge_wr    = psor_pkg::EIDX_MAX_W'(r_ewp);
        o_cmd.edge_rd    = psor_pkg::EIDX_MAX_W'(r_eptr);
        o_cmd.win_count  = psor_pkg::WCNT_MAX_W'(win_cnt);
        o_cmd.kept_count = kept_sat;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kk   = r_k;
                    n_last = i_last;
                    if (r_k == '0) begin
                        n_mode = r_enable;
                    end
                    if (stored) begin
                        o_cmd.capture = 1'b1;
                        n_k       = r_k + CW'(1);
                        n_wr_slot = wr_slot_nx;
                        if (!mode_now) begin
                            n_state = S_EMIT_IN;
                        end else if (r_k != '0) begin
                            n_phase = 3'd0;
                            n_state = S_SQ;
                        end else begin
                            n_state = S_POST;
                        end
                    end else begin
                        n_state = S_POST;
                    end
                end
            end
            S_EMIT_IN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = psor_pkg::OSEL_CUR;
                    n_kept  = r_kept + CW'(1);
                    n_state = S_POST;
                end
            end
            S_SQ: begin
                o_cmd.sq_run = 1'b1;
                if (r_phase == 3'd4) begin
                    n_state = S_SQI;
                end else begin
                    n_phase = r_phase + 3'd1;
                end
            end
            S_SQI: begin
                o_cmd.sqrt_init = 1'b1;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (i_stat.sqrt_done) begin
                    o_cmd.edge_we = 1'b1;
                    n_ewp   = ewp_nx;
                    n_state = (r_kk >= CW'(HALF_WINDOW)) ? S_DSETUP : S_POST;
                end else begin
                    o_cmd.sqrt_step = 1'b1;
                end
            end
            S_DSETUP: begin
                if (win_ok) begin
                    o_cmd.sum_clr = 1'b1;
                    n_ecnt  = win_cnt;
                    n_eptr  = eptr0;
                    n_state = S_DSUM;
                end else begin
                    n_dec      = r_dec + CW'(1);
                    n_dec_slot = dec_slot_nx;
                    n_dec_edge = dec_edge_nx;
                    n_state    = dec_done_state;
                end
            end
            S_DSUM: begin
                o_cmd.sum_add = 1'b1;
                n_eptr = eptr_nx;
                n_ecnt = r_ecnt - NW'(1);
                if (r_ecnt == NW'(1)) begin
                    n_state = S_DCMP;
                end
            end
            S_DCMP: begin
                if (i_stat.keep) begin
                    n_state = S_DEMIT;
                end else begin
                    n_dec      = r_dec + CW'(1);
                    n_dec_slot = dec_slot_nx;
                    n_dec_edge = dec_edge_nx;
                    n_state    = dec_done_state;
                end
            end
            S_DEMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = psor_pkg::OSEL_MEM;
                    n_kept     = r_kept + CW'(1);
                    n_dec      = r_dec + CW'(1);
                    n_dec_slot = dec_slot_nx;
                    n_dec_edge = dec_edge_nx;
                    n_state    = dec_done_state;
                end
            end
            S_POST: begin
                if (r_last) begin
                    if (r_mode) begin
                        n_tail  = 1'b1;
                        n_state = S_TAILCHK;
                    end else begin
                        n_state = S_END;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TAILCHK: begin
                n_state = (r_dec < r_k) ? S_DSETUP : S_END;
            end
            S_END: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = psor_pkg::OSEL_END;
                    n_k        = '0;
                    n_dec      = '0;
                    n_dec_slot = '0;
                    n_dec_edge = '0;
                    n_wr_slot  = '0;
                    n_ewp      = '0;
                    n_kept     = '0;
                    n_tail     = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_k        <= '0;
            r_kk       <= '0;
            r_dec      <= '0;
            r_dec_slot <= '0;
            r_dec_edge <= '0;
            r_wr_slot  <= '0;
            r_ewp      <= '0;
            r_kept     <= '0;
            r_mode     <= 1'b1;
            r_enable   <= 1'b1;
            r_last     <= 1'b0;
            r_tail     <= 1'b0;
            r_phase    <= '0;
            r_ecnt     <= '0;
            r_eptr     <= '0;
        end else begin
            r_state    <= n_state;
            r_k        <= n_k;
            r_kk       <= n_kk;
            r_dec      <= n_dec;
            r_dec_slot <= n_dec_slot;
            r_dec_edge <= n_dec_edge;
            r_wr_slot  <= n_wr_slot;
            r_ewp      <= n_ewp;
            r_kept     <= n_kept;
            r_mode     <= n_mode;
            r_last     <= n_last;
            r_tail     <= n_tail;
            r_phase    <= n_phase;
            r_ecnt     <= n_ecnt;
            r_eptr     <= n_eptr;
            if (i_cfg_we && i_cfg_idx == psor_pkg::REG_FILTER_ENABLED) begin
                r_enable <= i_cfg_data[0];
            end
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

[sv/point_stream_outlier_removal.sv]
// Streaming outlier filter for laser-scan points.
// Input requests carry one 3D point with its pixel position; last_in_frame closes a
// frame. Output requests carry either a kept point or, after the last kept point of a
// frame, one frame-end request holding the number of kept points (saturated at 65535).
// Both channels use valid/ready. The configuration port writes filter_enabled (index 0)
// and distance_threshold (index 1); write only while the block is idle.
// With filtering on, each stored point after the first of a frame costs one edge length:
// the squared distance to the previous point is built in a short multiply pipeline, then
// an iterative square root is taken. Deciding a point sums up to 2*HALF_WINDOW stored
// edges, one per cycle, after a setup step and before a compare and, for a kept point,
// emission. The frame end adds up to HALF_WINDOW such decisions.
// With the filter disabled a point goes from S_EMIT_IN into the output register once
// the output is free, and the next point is taken after S_POST.
// A point is decided HALF_WINDOW requests after it arrives, or at the end of its frame.
// The output sits in a register, so a stalled receiver only holds the controller when
// a second result is ready; the input is taken again once the current item is done.
// Reset clears the frame counters, enables filtering and sets the threshold to 128 (edge length units).
module point_stream_outlier_removal #(
    parameter int HALF_WINDOW      = 3,
    parameter int MAX_FRAME_POINTS = 65535
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  psor_pkg::t_in                   i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output psor_pkg::t_out                  o_out,
    input  logic                            i_cfg_we,
    input  logic [psor_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psor_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    psor_pkg::t_dp_cmd  cmd;
    psor_pkg::t_dp_stat stat;

    // The controller owns frame bookkeeping and sequencing.
    psor_ctrl #(
        .HALF_WINDOW      (HALF_WINDOW),
        .MAX_FRAME_POINTS (MAX_FRAME_POINTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_last     (i_in.last_in_frame),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // The datapath holds pending points, edges, the arithmetic and the output register.
    psor_dpath #(
        .HALF_WINDOW (HALF_WINDOW)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

[sim/point_stream_outlier_removal_tb.sv]
`timescale 1ns / 1ps

module point_stream_outlier_removal_tb;

    localparam int HALF_WIN = 3;
    localparam int EDGE_SLOTS = 2 * HALF_WIN;
    localparam int PEND_SLOTS = HALF_WIN + 1;
    localparam int FRAME_CAP = 65535;
    localparam longint CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 400;

    // Scoreboard: carries its own copy of the filter state and predicts the
    // output requests that each accepted input request causes.
    class outlier_scoreboard;
        bit                 filt_en;
        bit [23:0]          threshold;
        bit [24:0]          edges[EDGE_SLOTS];
        psor_pkg::t_point   held[PEND_SLOTS];
        int unsigned        seen;
        int unsigned        kept;
        bit                 frame_filt;
        psor_pkg::t_out     pending_q[$];
        int                 errors;

        function void reset_state();
            filt_en = 1;
            threshold = 24'd128;
            foreach (edges[k]) edges[k] = '0;
            seen = 0;
            kept = 0;
            frame_filt = 1;
            pending_q.delete();
            errors = 0;
        endfunction

        function void write_reg(logic [psor_pkg::CFG_IDX_W-1:0] idx,
                                logic [psor_pkg::CFG_DATA_W-1:0] val);
            if (idx == psor_pkg::REG_FILTER_ENABLED) filt_en = val[0];
            else threshold = val;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned b;
            root = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= root + b) begin
                    v -= root + b;
                    root = (root >> 1) + b;
                end else begin
                    root >>= 1;
                end
                b >>= 2;
            end
            return root;
        endfunction

        function longint unsigned abs_delta(logic [23:0] a, logic [23:0] b);
            longint d;
            d = longint'($signed(a)) - longint'($signed(b));
            return (d < 0) ? -d : d;
        endfunction

        function bit [24:0] edge_len(psor_pkg::t_point a, psor_pkg::t_point b);
            longint unsigned dx, dy, dz;
            dx = abs_delta(a.x, b.x);
            dy = abs_delta(a.y, b.y);
            dz = abs_delta(a.z, b.z);
            return 25'(int_sqrt(dx * dx + dy * dy + dz * dz));
        endfunction

        function void push_point(psor_pkg::t_point p);
            psor_pkg::t_out r;
            r = '0;
            r.out_x = p.x;
            r.out_y = p.y;
            r.out_z = p.z;
            r.out_col = p.col;
            r.out_row = p.row;
            pending_q.insert(pending_q.size(), r);
            kept++;
        endfunction

        // Mean edge length over the clipped window, tested without division.
        function void judge(int unsigned i, int unsigned last_idx);
            int unsigned lo, hi;
            longint unsigned total;
            lo = (i >= HALF_WIN) ? i - HALF_WIN : 0;
            hi = i + HALF_WIN;
            if (hi > last_idx) hi = last_idx;
            if (hi <= lo) return;
            total = 0;
            for (int unsigned e = lo; e < hi; e++) total += edges[e % EDGE_SLOTS];
            if (total < longint'(threshold) * longint'(hi - lo))
                push_point(held[i % PEND_SLOTS]);
        endfunction

        function void note_input(psor_pkg::t_in req);
            int unsigned k;
            psor_pkg::t_out r;
            k = seen;
            if (k == 0) frame_filt = filt_en;
            if (k < FRAME_CAP) begin
                held[k % PEND_SLOTS] = {req.coord_x, req.coord_y, req.coord_z,
                                        req.pixel_col, req.pixel_row};
                seen = k + 1;
                if (!frame_filt) begin
                    push_point(held[k % PEND_SLOTS]);
                end else begin
                    if (k > 0)
                        edges[(k - 1) % EDGE_SLOTS] =
                            edge_len(held[(k - 1) % PEND_SLOTS], held[k % PEND_SLOTS]);
                    if (k >= HALF_WIN) judge(k - HALF_WIN, k);
                end
            end
            if (req.last_in_frame) begin
                if (frame_filt)
                    for (int unsigned i = (seen > HALF_WIN) ? seen - HALF_WIN : 0;
                         i < seen; i++)
                        judge(i, seen - 1);
                r = '0;
                r.is_frame_end = 1;
                r.kept_count = (kept > 65535) ? 16'hFFFF : kept[15:0];
                pending_q.insert(pending_q.size(), r);
                seen = 0;
                kept = 0;
            end
        endfunction

        function void check_output(psor_pkg::t_out got);
            psor_pkg::t_out exp;
            if (pending_q.size() == 0) begin
                $error("unexpected output request %h", got);
                errors++;
                return;
            end
            exp = pending_q.pop_front();
            if (got.out_x !== exp.out_x) begin
                $error("out_x expected %h actual %h", exp.out_x, got.out_x); errors++;
            end
            if (got.out_y !== exp.out_y) begin
                $error("out_y expected %h actual %h", exp.out_y, got.out_y); errors++;
            end
            if (got.out_z !== exp.out_z) begin
                $error("out_z expected %h actual %h", exp.out_z, got.out_z); errors++;
            end
            if (got.out_col !== exp.out_col) begin
                $error("out_col expected %h actual %h", exp.out_col, got.out_col); errors++;
            end
            if (got.out_row !== exp.out_row) begin
                $error("out_row expected %h actual %h", exp.out_row, got.out_row); errors++;
            end
            if (got.is_frame_end !== exp.is_frame_end) begin
                $error("is_frame_end expected %b actual %b", exp.is_frame_end,
                       got.is_frame_end);
                errors++;
            end
            if (got.kept_count !== exp.kept_count) begin
                $error("kept_count expected %0d actual %0d", exp.kept_count,
                       got.kept_count);
                errors++;
            end
        endfunction
    endclass

    logic                            i_clk = 0;
    logic                            i_rst_n = 0;
    logic                            i_in_valid = 0;
    logic                            o_in_ready;
    psor_pkg::t_in                   i_in = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 0;
    psor_pkg::t_out                  o_out;
    logic                            i_cfg_we = 0;
    logic [psor_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [psor_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    outlier_scoreboard filt_model;
    longint cycle_count = 0;
    bit     sink_done = 0;

    point_stream_outlier_removal dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Watchdog: the run must finish well inside this many cycles.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mostly short gaps with an occasional long one; zero is common so that
    // back-to-back stretches also occur.
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // Receiver: ready toggles randomly; results are sampled at the edge where
    // valid and ready are both high.
    initial begin
        int hold;
        @(posedge i_clk iff i_rst_n);
        while (!sink_done) begin
            hold = gap_len();
            if (hold == 0) begin
                i_out_ready <= 1;
            end else begin
                i_out_ready <= 0;
                repeat (hold) @(posedge i_clk);
                i_out_ready <= 1;
            end
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) filt_model.check_output(o_out);
        end
    end

    // Valid is left high after acceptance so that a following request can
    // start in the same cycle; it drops for a gap or when the stream pauses.
    task automatic send_point(input psor_pkg::t_in req);
        int hold;
        hold = gap_len();
        if (hold > 0) begin
            i_in_valid <= 0;
            repeat (hold) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in <= req;
        do @(posedge i_clk); while (!o_in_ready);
        filt_model.note_input(req);
    endtask

    task automatic write_cfg(input logic [psor_pkg::CFG_IDX_W-1:0] idx,
                             input logic [psor_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        filt_model.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Waits until every predicted request is out, then lets the block finish
    // any decision that drops its point before touching the registers.
    task automatic wait_idle();
        i_in_valid <= 0;
        while (filt_model.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic psor_pkg::t_in rand_point(input bit last, input int spread);
        psor_pkg::t_in p;
        p.coord_x = $urandom;
        p.coord_y = $urandom;
        p.coord_z = $urandom;
        if (spread > 0) begin
            p.coord_x = 24'($signed($urandom_range(0, 2 * spread)) - spread);
            p.coord_y = 24'($signed($urandom_range(0, 2 * spread)) - spread);
            p.coord_z = 24'($signed($urandom_range(0, 2 * spread)) - spread);
        end
        p.pixel_col = $urandom;
        p.pixel_row = $urandom;
        p.last_in_frame = last;
        return p;
    endfunction

    // A well-formed frame of points walking in small steps, so edges land on
    // both sides of the threshold; an occasional wild point makes an outlier.
    task automatic send_frame(input int len);
        psor_pkg::t_in p;
        int step;
        p = rand_point(0, 2000);
        step = $urandom_range(1, 300);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                p = rand_point(0, 0);
            end else begin
                p.coord_x = p.coord_x + 24'($signed($urandom_range(0, 2 * step)) - step);
                p.coord_y = p.coord_y + 24'($signed($urandom_range(0, 2 * step)) - step);
                p.coord_z = p.coord_z + 24'($signed($urandom_range(0, 2 * step)) - step);
                p.pixel_col = $urandom;
                p.pixel_row = $urandom;
            end
            p.last_in_frame = (i == len - 1);
            send_point(p);
        end
    endtask

    initial begin
        psor_pkg::t_in p;
        int sent;
        filt_model = new();
        filt_model.reset_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: a single-point frame (no edges, dropped), then a frame
        // touching the coordinate extremes, which yields the longest edges.
        send_point(rand_point(1, 0));
        p = '0;
        p.coord_x = 24'h7FFFFF; p.coord_y = 24'h800000; p.coord_z = 24'h7FFFFF;
        p.pixel_col = 16'hFFFF; p.pixel_row = 16'h0000;
        send_point(p);
        p.coord_x = 24'h800000; p.coord_y = 24'h7FFFFF; p.coord_z = 24'h800000;
        p.pixel_col = 16'h0000; p.pixel_row = 16'hFFFF;
        send_point(p);
        p = '0;
        send_point(p);
        p.last_in_frame = 1;
        send_point(p);
        // Identical points give zero edges, which pass any nonzero threshold.
        p = '0; p.coord_x = 24'h000100;
        for (int i = 0; i < 5; i++) begin
            p.last_in_frame = (i == 4);
            send_point(p);
        end
        wait_idle();

        // Threshold of zero: nothing can be kept.
        write_cfg(psor_pkg::REG_DISTANCE_THRESHOLD, 24'd0);
        send_frame(6);
        wait_idle();
        // Largest threshold: points with an edge are kept unless wild points push the window mean past it.
        write_cfg(psor_pkg::REG_DISTANCE_THRESHOLD, 24'hFFFFFF);
        send_frame(4);
        send_frame(2);
        wait_idle();
        // Disabled: points pass straight through, single-point frame included.
        write_cfg(psor_pkg::REG_FILTER_ENABLED, 24'd0);
        send_frame(3);
        send_point(rand_point(1, 0));
        wait_idle();
        write_cfg(psor_pkg::REG_FILTER_ENABLED, 24'd1);
        write_cfg(psor_pkg::REG_DISTANCE_THRESHOLD, 24'd128);

        // Random part: frames of varied length under changing settings.
        sent = 0;
        while (sent < 220) begin
            int len;
            if ($urandom_range(0, 4) == 0) begin
                wait_idle();
                write_cfg(psor_pkg::REG_FILTER_ENABLED,
                          psor_pkg::CFG_DATA_W'($urandom_range(0, 3) != 0));
                write_cfg(psor_pkg::REG_DISTANCE_THRESHOLD, $urandom_range(0, 3) == 0 ?
                          24'($urandom) : 24'($urandom_range(0, 600)));
            end
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3)
                                              : $urandom_range(4, 14);
            if ($urandom_range(0, 7) == 0) begin
                // Noise: uncorrelated points with full-range fields.
                for (int i = 0; i < len; i++) send_point(rand_point(i == len - 1, 0));
            end else begin
                send_frame(len);
            end
            sent += len;
        end

        wait_idle();
        sink_done = 1;
        @(posedge i_clk);
        if (filt_model.errors == 0 && filt_model.pending_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
